// ===== rtl/core/esng_pkg.sv =====
// Package for the enveloped sine note generator: sizes, register codes,
// controller states, command/status structs and the quarter-wave sine table.
// Depends on nothing; every other file of the block imports it.
package esng_pkg;

    localparam int NOTE_LEN        = 48000;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;

    localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int QUARTER      = 1 << QUARTER_BITS;
    localparam int ROM_AW       = QUARTER_BITS + 1;

    localparam int PHASE_STEP_W = 32;
    localparam int SAMPLE_W     = 16;
    localparam int INDEX_W      = 16;
    localparam int CFG_W        = 15;
    localparam int MAG_W        = 15;
    localparam int PROD_W       = MAG_W + INDEX_W;
    localparam int DIV_STEPS    = MAG_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0]   GAIN_RESET = CFG_W'(251);
    localparam logic [CFG_W-1:0]   RAMP_RESET = CFG_W'(24000);
    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(NOTE_LEN - 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [0:0] {
        CFG_GAIN = 1'b0,
        CFG_RAMP = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_GAIN,
        S_ATK_MUL,
        S_DIV_A,
        S_END_A,
        S_REL_MUL,
        S_DIV_R,
        S_END_R,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic gain_mul;
        logic atk_load;
        logic rel_load;
        logic div_step;
        logic div_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic playing;
        logic atk;
        logic rel;
    } t_status;

    typedef logic [MAG_W-1:0] t_qsine_rom [0:QUARTER];

    // First-quadrant sine in Q1.15 from a Taylor series to x^13, computed
    // with unsigned Q2.30 integers and truncating shifts and divisions.
    function automatic t_qsine_rom build_qsine();
        t_qsine_rom         rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (64'(k) * HALF_PI_Q30 + 64'(QUARTER / 2)) >> QUARTER_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 64'sd16384) >>> 15;
            if (r > 64'sd32767) begin
                r = 64'sd32767;
            end
            rom[k] = MAG_W'(r);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/esng_in_if.sv =====
// Input channel of the note generator: valid/ready handshake with the
// op and phase_step payload. Depends on esng_pkg.
interface esng_in_if;
    import esng_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [PHASE_STEP_W-1:0] phase_step;

    modport source (output valid, output op, output phase_step, input ready);
    modport sink   (input valid, input op, input phase_step, output ready);
endinterface

// ===== rtl/core/esng_out_if.sv =====
// Output channel of the note generator: valid/ready handshake with the
// sample, last and active payload. Depends on esng_pkg.
interface esng_out_if;
    import esng_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       active;

    modport source (output valid, output sample, output last, output active, input ready);
    modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

// ===== rtl/core/esng_ctrl.sv =====
// Controller of the note generator: state machine that sequences table read,
// gain multiply, envelope divides and result transfer. Depends on esng_pkg.
module esng_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  esng_pkg::t_status i_status,
    output esng_pkg::t_cmd    o_cmd
);
    import esng_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;
    logic             cnt_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_LOOK;
            S_LOOK:    n_state = i_status.playing ? S_GAIN : S_OUT;
            S_GAIN: begin
                if (i_status.atk) begin
                    n_state = S_ATK_MUL;
                end else if (i_status.rel) begin
                    n_state = S_REL_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ATK_MUL: n_state = S_DIV_A;
            S_DIV_A:   if (cnt_last) n_state = S_END_A;
            S_END_A:   n_state = i_status.rel ? S_REL_MUL : S_OUT;
            S_REL_MUL: n_state = S_DIV_R;
            S_DIV_R:   if (cnt_last) n_state = S_END_R;
            S_END_R:   n_state = S_OUT;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_GAIN:    o_cmd.gain_mul = 1'b1;
            S_ATK_MUL: begin
                o_cmd.atk_load = 1'b1;
                n_cnt          = '0;
            end
            S_REL_MUL: begin
                o_cmd.rel_load = 1'b1;
                n_cnt          = '0;
            end
            S_DIV_A, S_DIV_R: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
            end
            S_END_A, S_END_R: o_cmd.div_end = 1'b1;
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/esng_datapath.sv =====
// Datapath of the note generator: oscillator state, configuration registers,
// sine table, shared multiplier, bit-serial divider and result register.
// Depends on esng_pkg; driven by esng_ctrl commands.
module esng_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  esng_pkg::t_cmd                      i_cmd,
    output esng_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  esng_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [esng_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_op,
    input  logic [esng_pkg::PHASE_STEP_W-1:0]   i_phase_step,
    output logic signed [esng_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                o_last,
    output logic                                o_active
);
    import esng_pkg::*;

    localparam t_qsine_rom QSINE = build_qsine();

    logic [CFG_W-1:0]           r_gain;
    logic [CFG_W-1:0]           r_ramp;
    logic [PHASE_BITS-1:0]      r_phase_acc;
    logic [PHASE_BITS-1:0]      r_note_step;
    logic [INDEX_W-1:0]         r_index;
    logic                       r_playing;
    logic [MAG_W-1:0]           r_rom;
    logic [MAG_W-1:0]           r_mag;
    logic [MAG_W-1:0]           r_rem;
    logic [MAG_W-1:0]           r_quo;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_last;
    logic                       r_active;

    logic [SINE_TABLE_BITS-1:0] tbl_idx;
    logic [ROM_AW-1:0]          rom_addr;
    logic [INDEX_W-1:0]         factor;
    logic [MAG_W-1:0]           mul_a;
    logic [INDEX_W-1:0]         mul_b;
    logic [PROD_W-1:0]          prod;
    logic [MAG_W:0]             shifted;
    logic                       is_last;
    logic [SAMPLE_W-1:0]        mag_ext;

    assign tbl_idx  = r_phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign rom_addr = tbl_idx[QUARTER_BITS]
                    ? ROM_AW'(QUARTER) - {1'b0, tbl_idx[QUARTER_BITS-1:0]}
                    : {1'b0, tbl_idx[QUARTER_BITS-1:0]};
    assign factor   = LAST_INDEX - r_index;
    assign is_last  = (r_index >= LAST_INDEX);

    assign o_status.playing = r_playing;
    assign o_status.atk     = (r_index < INDEX_W'(r_ramp));
    assign o_status.rel     = ((17'(r_index) + 17'(r_ramp)) >= 17'(NOTE_LEN))
                           && (r_ramp != '0);

    // One multiplier, shared by the gain scaling and both envelope steps.
    always_comb begin
        mul_a = r_mag;
        mul_b = INDEX_W'(r_rom);
        if (i_cmd.gain_mul) begin
            mul_a = r_gain;
        end else if (i_cmd.atk_load) begin
            mul_b = r_index;
        end else if (i_cmd.rel_load) begin
            mul_b = factor;
        end
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign shifted = {r_rem, r_quo[MAG_W-1]};
    assign mag_ext = {1'b0, r_mag};

    always_ff @(posedge i_clk) begin
        r_rom <= QSINE[rom_addr];
    end

    // Magnitude path: the sign of the sine only enters at the result register,
    // so every division truncates toward zero as a plain unsigned division.
    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_mul) begin
            r_mag <= prod[2*MAG_W-1:MAG_W];
        end else if (i_cmd.div_end) begin
            r_mag <= r_quo;
        end
        if (i_cmd.atk_load || i_cmd.rel_load) begin
            r_rem <= prod[2*MAG_W-1:MAG_W];
            r_quo <= prod[MAG_W-1:0];
        end else if (i_cmd.div_step) begin
            if (shifted >= {1'b0, r_ramp}) begin
                r_rem <= MAG_W'(shifted - {1'b0, r_ramp});
                r_quo <= {r_quo[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[MAG_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_sample <= '0;
            r_last   <= 1'b0;
            r_active <= r_playing;
            if (r_playing) begin
                r_sample <= tbl_idx[SINE_TABLE_BITS-1] ? -$signed(mag_ext) : $signed(mag_ext);
                r_last   <= is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_ramp      <= RAMP_RESET;
            r_phase_acc <= '0;
            r_note_step <= '0;
            r_index     <= '0;
            r_playing   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN: r_gain <= i_cfg_data;
                    CFG_RAMP: r_ramp <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (i_cmd.accept && i_op) begin
                r_note_step <= i_phase_step[PHASE_BITS-1:0];
                r_phase_acc <= '0;
                r_index     <= '0;
                r_playing   <= 1'b1;
            end else if (i_cmd.out_load && r_playing) begin
                r_phase_acc <= r_phase_acc + r_note_step;
                if (is_last) begin
                    r_playing <= 1'b0;
                    r_index   <= '0;
                end else begin
                    r_index <= r_index + INDEX_W'(1);
                end
            end
        end
    end

    assign o_sample = r_sample;
    assign o_last   = r_last;
    assign o_active = r_active;

endmodule

// ===== rtl/core/enveloped_sine_note_generator_core.sv =====
// Top level of the enveloped sine note generator: joins the controller and
// the datapath. Depends on esng_pkg, esng_in_if, esng_out_if, esng_ctrl, esng_datapath.
//
//   Channel   Direction  Transfer when          Payload
//   i_in      in         valid && ready         op, phase_step
//   o_out     out        valid && ready         sample, last, active
//   i_cfg_*   in         i_cfg_we               i_cfg_index, i_cfg_data
//
// An idle tick (no note playing) goes from acceptance through the lookup state to the
// result load. A note sample also takes the gain multiply and, per envelope ramp it lies
// in, a multiply, a bit-serial divide of one quotient bit per cycle and an end step.
// Reset is synchronous and active low; it restores gain 251, ramp length 24000 and idle.
// The result register frees the input side: a new item is taken while a result
// waits, and only the final load stalls until the previous result has been taken.
module enveloped_sine_note_generator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    esng_in_if.sink                    i_in,
    esng_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  esng_pkg::t_cfg_idx         i_cfg_index,
    input  logic [esng_pkg::CFG_W-1:0] i_cfg_data
);
    import esng_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_cmd    cmd;
    t_status status;

    // The controller owns the handshakes and the sequence of one item's work.
    esng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the oscillator state, the configuration registers,
    // the sine table, the arithmetic and the result register.
    esng_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_in.op),
        .i_phase_step (i_in.phase_step),
        .o_sample     (o_out.sample),
        .o_last       (o_out.last),
        .o_active     (o_out.active)
    );

endmodule
